@@ rtl/lbad_pkg.sv @@
package lbad_pkg;

    localparam int PAGES     = 2;
    localparam int PAGE_W    = 1;
    localparam int LAT_W     = 16;
    localparam int CNT_W     = 8;
    localparam int PCT_W     = 7;
    localparam int CLR_W     = 4;
    localparam int PROD_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [LAT_W-1:0] L1_LIMIT_RST   = 16'd100;
    localparam logic [LAT_W-1:0] L3_LIMIT_RST   = 16'd230;
    localparam logic [LAT_W-1:0] MISS_LIMIT_RST = 16'd450;
    localparam logic [CNT_W-1:0] BATCH_RST      = 8'd8;
    localparam logic [PCT_W-1:0] ATTACK_PCT_RST = 7'd50;
    localparam logic [PCT_W-1:0] THROT_PCT_RST  = 7'd90;
    localparam logic [CLR_W-1:0] CLEAR_RST      = 4'd2;

    localparam logic [PROD_W-1:0] HUNDRED = 15'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_LIMIT      = 3'd0,
        CFG_L3_LIMIT      = 3'd1,
        CFG_MISS_LIMIT    = 3'd2,
        CFG_BATCH_LEN     = 3'd3,
        CFG_ATTACK_PCT    = 3'd4,
        CFG_THROTTLE_PCT  = 3'd5,
        CFG_CLEAR_BATCHES = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PCT_W-1:0] attack_pct;
        logic [PCT_W-1:0] throttle_pct;
        logic [CLR_W-1:0] clear_batches;
        logic [CNT_W-1:0] batch;
    } t_judge_cfg;

    typedef struct packed {
        logic             flag;
        logic [CLR_W-1:0] progress;
    } t_flag_state;

    typedef struct packed {
        logic        attack;
        logic        raised;
        logic        throttle;
        t_flag_state next_flag;
    } t_verdict;

endpackage

@@ rtl/latency_bin_attack_detector_unit.sv @@
// latency bin attack detector
// input channel: one transaction per timed reload (i_page_index, i_latency),
// accepted when i_in_valid is high and o_in_stall is low. each sample is
// binned against the l1/l3/miss limits into the per-page counters.
// output channel: one transaction per completed batch, presented with
// o_out_valid and taken when i_out_stall is low; it carries the four counts,
// the attack and throttle verdicts and the hysteresis flag state.
// configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
// (0 l1_limit .. 6 clear_batches); write only while the block is idle.
// path: a sample is registered at acceptance, binned and judged from the
// input register, and its report is registered in the output register.
// throughput: one sample per cycle, set by the single binning stage.
// a stall on the output holds the report; the stage then holds only a
// sample that completes a batch, and the input stalls behind it.
// reset: counters, flag, clear progress and both valids are cleared and the
// registers take their default values.
module latency_bin_attack_detector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lbad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lbad_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lbad_pkg::PAGE_W-1:0]       i_page_index,
    input  logic [lbad_pkg::LAT_W-1:0]        i_latency,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lbad_pkg::PAGE_W-1:0]       o_report_page,
    output logic [lbad_pkg::CNT_W-1:0]        o_l1_count,
    output logic [lbad_pkg::CNT_W-1:0]        o_l3_count,
    output logic [lbad_pkg::CNT_W-1:0]        o_miss_count,
    output logic [lbad_pkg::CNT_W-1:0]        o_big_miss_count,
    output logic                              o_attack_batch,
    output logic                              o_attack_raised,
    output logic                              o_attack_active,
    output logic                              o_throttle_request
);

    // configuration registers
    logic [lbad_pkg::LAT_W-1:0] r_l1_limit;
    logic [lbad_pkg::LAT_W-1:0] r_l3_limit;
    logic [lbad_pkg::LAT_W-1:0] r_miss_limit;
    logic [lbad_pkg::CNT_W-1:0] r_batch_len;
    logic [lbad_pkg::PCT_W-1:0] r_attack_pct;
    logic [lbad_pkg::PCT_W-1:0] r_throttle_pct;
    logic [lbad_pkg::CLR_W-1:0] r_clear_batches;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_limit      <= lbad_pkg::L1_LIMIT_RST;
            r_l3_limit      <= lbad_pkg::L3_LIMIT_RST;
            r_miss_limit    <= lbad_pkg::MISS_LIMIT_RST;
            r_batch_len     <= lbad_pkg::BATCH_RST;
            r_attack_pct    <= lbad_pkg::ATTACK_PCT_RST;
            r_throttle_pct  <= lbad_pkg::THROT_PCT_RST;
            r_clear_batches <= lbad_pkg::CLEAR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (lbad_pkg::t_cfg_idx'(i_cfg_index))
                lbad_pkg::CFG_L1_LIMIT:      r_l1_limit      <= i_cfg_wdata;
                lbad_pkg::CFG_L3_LIMIT:      r_l3_limit      <= i_cfg_wdata;
                lbad_pkg::CFG_MISS_LIMIT:    r_miss_limit    <= i_cfg_wdata;
                lbad_pkg::CFG_BATCH_LEN:     r_batch_len     <= i_cfg_wdata[lbad_pkg::CNT_W-1:0];
                lbad_pkg::CFG_ATTACK_PCT:    r_attack_pct    <= i_cfg_wdata[lbad_pkg::PCT_W-1:0];
                lbad_pkg::CFG_THROTTLE_PCT:  r_throttle_pct  <= i_cfg_wdata[lbad_pkg::PCT_W-1:0];
                lbad_pkg::CFG_CLEAR_BATCHES: r_clear_batches <= i_cfg_wdata[lbad_pkg::CLR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    logic                        r_in_valid;
    logic [lbad_pkg::PAGE_W-1:0] r_in_page;
    logic [lbad_pkg::LAT_W-1:0]  r_in_lat;

    // per-page state
    logic [lbad_pkg::CNT_W-1:0] r_l1_bins   [lbad_pkg::PAGES];
    logic [lbad_pkg::CNT_W-1:0] r_l3_bins   [lbad_pkg::PAGES];
    logic [lbad_pkg::CNT_W-1:0] r_miss_bins [lbad_pkg::PAGES];
    logic [lbad_pkg::CNT_W-1:0] r_big_bins  [lbad_pkg::PAGES];
    logic [lbad_pkg::CNT_W-1:0] r_samples   [lbad_pkg::PAGES];
    lbad_pkg::t_flag_state      r_flag;

    // output register
    logic                        r_out_valid;
    logic [lbad_pkg::PAGE_W-1:0] r_out_page;
    logic [lbad_pkg::CNT_W-1:0]  r_out_l1;
    logic [lbad_pkg::CNT_W-1:0]  r_out_l3;
    logic [lbad_pkg::CNT_W-1:0]  r_out_miss;
    logic [lbad_pkg::CNT_W-1:0]  r_out_big;
    logic                        r_out_attack;
    logic                        r_out_raised;
    logic                        r_out_active;
    logic                        r_out_throttle;

    logic                       in_range;
    logic                       is_l1;
    logic                       is_l3;
    logic                       is_miss;
    logic [lbad_pkg::CNT_W-1:0] n_l1;
    logic [lbad_pkg::CNT_W-1:0] n_l3;
    logic [lbad_pkg::CNT_W-1:0] n_miss;
    logic [lbad_pkg::CNT_W-1:0] n_big;
    logic [lbad_pkg::CNT_W-1:0] n_samples;
    logic [lbad_pkg::CNT_W-1:0] batch;
    logic                       done;
    logic                       fire;
    logic                       accept;
    lbad_pkg::t_judge_cfg       judge_cfg;
    lbad_pkg::t_verdict         verdict;

    assign in_range = (32'(r_in_page) < lbad_pkg::PAGES);

    // the l1 bin takes priority over l3, and l3 over miss, where limits overlap
    assign is_l1   = (r_in_lat < r_l1_limit);
    assign is_l3   = !is_l1 && (r_in_lat < r_l3_limit);
    assign is_miss = !is_l1 && !is_l3 && (r_in_lat < r_miss_limit);

    always_comb begin
        n_l1      = r_l1_bins[r_in_page] + lbad_pkg::CNT_W'(is_l1);
        n_l3      = r_l3_bins[r_in_page] + lbad_pkg::CNT_W'(is_l3);
        n_miss    = r_miss_bins[r_in_page] + lbad_pkg::CNT_W'(is_miss);
        n_big     = r_big_bins[r_in_page] + lbad_pkg::CNT_W'(!is_l1 && !is_l3 && !is_miss);
        n_samples = r_samples[r_in_page] + 1'b1;
    end

    assign batch = (r_batch_len == '0) ? lbad_pkg::CNT_W'(1) : r_batch_len;
    assign done  = in_range && (n_samples >= batch);

    assign judge_cfg.attack_pct    = r_attack_pct;
    assign judge_cfg.throttle_pct  = r_throttle_pct;
    assign judge_cfg.clear_batches = r_clear_batches;
    assign judge_cfg.batch         = batch;

    lbad_judge u_judge (
        .i_l1_count (n_l1),
        .i_cfg      (judge_cfg),
        .i_flag     (r_flag),
        .o_verdict  (verdict)
    );

    // a sample that completes a batch waits while the report slot is held
    assign fire       = r_in_valid && (!done || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_page <= i_page_index;
            r_in_lat  <= i_latency;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < lbad_pkg::PAGES; p++) begin
                r_l1_bins[p]   <= '0;
                r_l3_bins[p]   <= '0;
                r_miss_bins[p] <= '0;
                r_big_bins[p]  <= '0;
                r_samples[p]   <= '0;
            end
            r_flag <= '0;
        end else if (fire && in_range) begin
            if (done) begin
                r_l1_bins[r_in_page]   <= '0;
                r_l3_bins[r_in_page]   <= '0;
                r_miss_bins[r_in_page] <= '0;
                r_big_bins[r_in_page]  <= '0;
                r_samples[r_in_page]   <= '0;
                r_flag                 <= verdict.next_flag;
            end else begin
                r_l1_bins[r_in_page]   <= n_l1;
                r_l3_bins[r_in_page]   <= n_l3;
                r_miss_bins[r_in_page] <= n_miss;
                r_big_bins[r_in_page]  <= n_big;
                r_samples[r_in_page]   <= n_samples;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && done) begin
            r_out_page     <= r_in_page;
            r_out_l1       <= n_l1;
            r_out_l3       <= n_l3;
            r_out_miss     <= n_miss;
            r_out_big      <= n_big;
            r_out_attack   <= verdict.attack;
            r_out_raised   <= verdict.raised;
            r_out_active   <= verdict.next_flag.flag;
            r_out_throttle <= verdict.throttle;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_report_page      = r_out_page;
    assign o_l1_count         = r_out_l1;
    assign o_l3_count         = r_out_l3;
    assign o_miss_count       = r_out_miss;
    assign o_big_miss_count   = r_out_big;
    assign o_attack_batch     = r_out_attack;
    assign o_attack_raised    = r_out_raised;
    assign o_attack_active    = r_out_active;
    assign o_throttle_request = r_out_throttle;

endmodule

@@ rtl/lbad_judge.sv @@
module lbad_judge (
    input  logic [lbad_pkg::CNT_W-1:0] i_l1_count,
    input  lbad_pkg::t_judge_cfg       i_cfg,
    input  lbad_pkg::t_flag_state      i_flag,
    output lbad_pkg::t_verdict         o_verdict
);

    logic [lbad_pkg::PROD_W-1:0] l1x100;
    logic [lbad_pkg::PROD_W-1:0] attack_lim;
    logic [lbad_pkg::PROD_W-1:0] throt_lim;
    logic                        mid_flag;
    logic [lbad_pkg::CLR_W-1:0]  mid_prog;
    logic                        attack;
    logic                        raised;

    assign l1x100     = lbad_pkg::PROD_W'(i_l1_count) * lbad_pkg::HUNDRED;
    assign attack_lim = lbad_pkg::PROD_W'(i_cfg.attack_pct) * lbad_pkg::PROD_W'(i_cfg.batch);
    assign throt_lim  = lbad_pkg::PROD_W'(i_cfg.throttle_pct) * lbad_pkg::PROD_W'(i_cfg.batch);
    assign attack     = (l1x100 <= attack_lim);

    always_comb begin
        mid_flag = i_flag.flag;
        mid_prog = i_flag.progress;
        raised   = 1'b0;
        if (attack && !i_flag.flag) begin
            mid_flag = 1'b1;
            raised   = 1'b1;
        end else if (!attack && i_flag.flag) begin
            mid_prog = i_flag.progress + 1'b1;
        end
        // hysteresis: flag drops once enough clean batches have been seen
        if (mid_prog >= i_cfg.clear_batches) begin
            mid_flag = 1'b0;
            mid_prog = '0;
        end
    end

    assign o_verdict.attack             = attack;
    assign o_verdict.raised             = raised;
    assign o_verdict.throttle           = (l1x100 <= throt_lim);
    assign o_verdict.next_flag.flag     = mid_flag;
    assign o_verdict.next_flag.progress = mid_prog;

endmodule

@@ test/latency_bin_attack_detector_unit_tb.sv @@
`timescale 1ns / 1ps

module latency_bin_attack_detector_unit_tb;

    localparam int RUN_LIMIT = 400000;

    typedef struct {
        logic [lbad_pkg::PAGE_W-1:0] page;
        logic [lbad_pkg::CNT_W-1:0]  l1;
        logic [lbad_pkg::CNT_W-1:0]  l3;
        logic [lbad_pkg::CNT_W-1:0]  miss;
        logic [lbad_pkg::CNT_W-1:0]  big_miss;
        logic                        attack;
        logic                        raised;
        logic                        active;
        logic                        throttle;
    } t_batch_report;

    typedef struct {
        logic [lbad_pkg::LAT_W-1:0] l1_limit;
        logic [lbad_pkg::LAT_W-1:0] l3_limit;
        logic [lbad_pkg::LAT_W-1:0] miss_limit;
        logic [lbad_pkg::CNT_W-1:0] batch;
        logic [lbad_pkg::PCT_W-1:0] attack_pct;
        logic [lbad_pkg::PCT_W-1:0] throttle_pct;
        logic [lbad_pkg::CLR_W-1:0] clear;
    } t_detector_settings;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    // per-page bin counters and attack hysteresis, plus the reports still owed
    class t_report_board;
        logic [lbad_pkg::LAT_W-1:0] l1_limit;
        logic [lbad_pkg::LAT_W-1:0] l3_limit;
        logic [lbad_pkg::LAT_W-1:0] miss_limit;
        logic [lbad_pkg::CNT_W-1:0] batch_len;
        logic [lbad_pkg::PCT_W-1:0] attack_pct;
        logic [lbad_pkg::PCT_W-1:0] throttle_pct;
        logic [lbad_pkg::CLR_W-1:0] clear_batches;
        logic [lbad_pkg::CNT_W-1:0] l1_bin[lbad_pkg::PAGES];
        logic [lbad_pkg::CNT_W-1:0] l3_bin[lbad_pkg::PAGES];
        logic [lbad_pkg::CNT_W-1:0] miss_bin[lbad_pkg::PAGES];
        logic [lbad_pkg::CNT_W-1:0] big_bin[lbad_pkg::PAGES];
        logic [lbad_pkg::CNT_W-1:0] samples[lbad_pkg::PAGES];
        logic                       attack_flag;
        logic [lbad_pkg::CLR_W-1:0] clear_progress;
        t_batch_report              pending_reports[$];
        int                         errors;
        int                         reports_seen;
        int                         attack_batches;
        int                         raises;
        int                         throttle_requests;

        function new();
            l1_limit      = lbad_pkg::L1_LIMIT_RST;
            l3_limit      = lbad_pkg::L3_LIMIT_RST;
            miss_limit    = lbad_pkg::MISS_LIMIT_RST;
            batch_len     = lbad_pkg::BATCH_RST;
            attack_pct    = lbad_pkg::ATTACK_PCT_RST;
            throttle_pct  = lbad_pkg::THROT_PCT_RST;
            clear_batches = lbad_pkg::CLEAR_RST;
            for (int p = 0; p < lbad_pkg::PAGES; p++) begin
                l1_bin[p]   = '0;
                l3_bin[p]   = '0;
                miss_bin[p] = '0;
                big_bin[p]  = '0;
                samples[p]  = '0;
            end
            attack_flag    = 1'b0;
            clear_progress = '0;
        endfunction

        function void set_register(lbad_pkg::t_cfg_idx idx,
                                   logic [lbad_pkg::CFG_DAT_W-1:0] value);
            case (idx)
                lbad_pkg::CFG_L1_LIMIT:      l1_limit      = value[lbad_pkg::LAT_W-1:0];
                lbad_pkg::CFG_L3_LIMIT:      l3_limit      = value[lbad_pkg::LAT_W-1:0];
                lbad_pkg::CFG_MISS_LIMIT:    miss_limit    = value[lbad_pkg::LAT_W-1:0];
                lbad_pkg::CFG_BATCH_LEN:     batch_len     = value[lbad_pkg::CNT_W-1:0];
                lbad_pkg::CFG_ATTACK_PCT:    attack_pct    = value[lbad_pkg::PCT_W-1:0];
                lbad_pkg::CFG_THROTTLE_PCT:  throttle_pct  = value[lbad_pkg::PCT_W-1:0];
                lbad_pkg::CFG_CLEAR_BATCHES: clear_batches = value[lbad_pkg::CLR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [lbad_pkg::PAGE_W-1:0] pg,
                                  logic [lbad_pkg::LAT_W-1:0] lat);
            int unsigned   batch;
            int unsigned   l1x100;
            t_batch_report r;
            if (pg >= lbad_pkg::PAGES)
                return;
            // lower bin wins when limits overlap
            if (lat < l1_limit)
                l1_bin[pg]++;
            else if (lat < l3_limit)
                l3_bin[pg]++;
            else if (lat < miss_limit)
                miss_bin[pg]++;
            else
                big_bin[pg]++;
            samples[pg]++;
            batch = (batch_len == 0) ? 1 : batch_len;
            if (samples[pg] < batch)
                return;

            l1x100     = l1_bin[pg] * 100;
            r.attack   = l1x100 <= attack_pct * batch;
            r.throttle = l1x100 <= throttle_pct * batch;
            r.raised   = 1'b0;
            if (r.attack && !attack_flag) begin
                attack_flag = 1'b1;
                r.raised    = 1'b1;
            end else if (!r.attack && attack_flag) begin
                clear_progress = clear_progress + 1'b1;
            end
            // attack batches leave the clear progress alone
            if (clear_progress >= clear_batches) begin
                attack_flag    = 1'b0;
                clear_progress = '0;
            end
            r.page     = pg;
            r.l1       = l1_bin[pg];
            r.l3       = l3_bin[pg];
            r.miss     = miss_bin[pg];
            r.big_miss = big_bin[pg];
            r.active   = attack_flag;
            pending_reports.push_back(r);
            attack_batches    += r.attack;
            raises            += r.raised;
            throttle_requests += r.throttle;

            l1_bin[pg]   = '0;
            l3_bin[pg]   = '0;
            miss_bin[pg] = '0;
            big_bin[pg]  = '0;
            samples[pg]  = '0;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_batch_report got);
            t_batch_report want;
            if (pending_reports.size() == 0) begin
                $display("%0t: report for page %0d with no completed batch pending",
                         $time, got.page);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            reports_seen++;
            compare_field("report_page", want.page, got.page);
            compare_field("l1_count", want.l1, got.l1);
            compare_field("l3_count", want.l3, got.l3);
            compare_field("miss_count", want.miss, got.miss);
            compare_field("big_miss_count", want.big_miss, got.big_miss);
            compare_field("attack_batch", want.attack, got.attack);
            compare_field("attack_raised", want.raised, got.raised);
            compare_field("attack_active", want.active, got.active);
            compare_field("throttle_request", want.throttle, got.throttle);
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [lbad_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [lbad_pkg::CFG_DAT_W-1:0] i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [lbad_pkg::PAGE_W-1:0]    i_page_index;
    logic [lbad_pkg::LAT_W-1:0]     i_latency;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [lbad_pkg::PAGE_W-1:0]    o_report_page;
    logic [lbad_pkg::CNT_W-1:0]     o_l1_count;
    logic [lbad_pkg::CNT_W-1:0]     o_l3_count;
    logic [lbad_pkg::CNT_W-1:0]     o_miss_count;
    logic [lbad_pkg::CNT_W-1:0]     o_big_miss_count;
    logic                           o_attack_batch;
    logic                           o_attack_raised;
    logic                           o_attack_active;
    logic                           o_throttle_request;

    t_report_board board = new();

    int cycle_count;
    int samples_sent;
    int settings_applied;
    int held_cycles;
    int hold_request_cycles;
    int burst_left;
    bit sender_gaps;

    latency_bin_attack_detector_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_page_index       (i_page_index),
        .i_latency          (i_latency),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_report_page      (o_report_page),
        .o_l1_count         (o_l1_count),
        .o_l3_count         (o_l3_count),
        .o_miss_count       (o_miss_count),
        .o_big_miss_count   (o_big_miss_count),
        .o_attack_batch     (o_attack_batch),
        .o_attack_raised    (o_attack_raised),
        .o_attack_active    (o_attack_active),
        .o_throttle_request (o_throttle_request)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, board.pending_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : report_monitor
        t_batch_report seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.page     = o_report_page;
            seen.l1       = o_l1_count;
            seen.l3       = o_l3_count;
            seen.miss     = o_miss_count;
            seen.big_miss = o_big_miss_count;
            seen.attack   = o_attack_batch;
            seen.raised   = o_attack_raised;
            seen.active   = o_attack_active;
            seen.throttle = o_throttle_request;
            board.check_report(seen);
        end
    end

    // receiver: stall modes of random length, plus an occasional long hold-off
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          mode_pos;
        i_out_stall <= 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        mode_pos  = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(STALL_PATTERN));
                mode_left = $urandom_range(200, 40);
                mode_pos  = 0;
            end
            mode_left--;
            mode_pos++;
            if (hold_request_cycles > 0) begin
                hold_request_cycles--;
                held_cycles++;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_LIGHT:   i_out_stall <= ($urandom_range(7) == 0);
                    STALL_HEAVY:   i_out_stall <= ($urandom_range(1) == 0);
                    STALL_PATTERN: i_out_stall <= ((mode_pos % 7) < 3);
                    default:       i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic offer_sample(input logic [lbad_pkg::PAGE_W-1:0] pg,
                                input logic [lbad_pkg::LAT_W-1:0] lat);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_gaps && $urandom_range(9) < 4) ? $urandom_range(8, 1) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_page_index <= pg;
        i_latency    <= lat;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(pg, lat);
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending_reports.size() != 0)
            @(posedge i_clk);
        // a trailing sample that completes no batch may still be in the stage
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_detector_settings s);
        lbad_pkg::t_cfg_idx             order[7];
        logic [lbad_pkg::CFG_DAT_W-1:0] vals[7];
        order = '{lbad_pkg::CFG_L1_LIMIT, lbad_pkg::CFG_L3_LIMIT, lbad_pkg::CFG_MISS_LIMIT,
                  lbad_pkg::CFG_BATCH_LEN, lbad_pkg::CFG_ATTACK_PCT,
                  lbad_pkg::CFG_THROTTLE_PCT, lbad_pkg::CFG_CLEAR_BATCHES};
        vals[0] = s.l1_limit;
        vals[1] = s.l3_limit;
        vals[2] = s.miss_limit;
        vals[3] = lbad_pkg::CFG_DAT_W'(s.batch);
        vals[4] = lbad_pkg::CFG_DAT_W'(s.attack_pct);
        vals[5] = lbad_pkg::CFG_DAT_W'(s.throttle_pct);
        vals[6] = lbad_pkg::CFG_DAT_W'(s.clear);
        wait_idle();
        for (int k = 0; k < 7; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            board.set_register(order[k], vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // bias is the chance in percent of an L1 hit; otherwise a slower bin or noise
    function automatic logic [lbad_pkg::LAT_W-1:0] pick_latency(input int bias);
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        r = $urandom_range(99);
        if (bias < 100 && r >= 94)
            return lbad_pkg::LAT_W'($urandom);
        if (r < bias && board.l1_limit != 0)
            return lbad_pkg::LAT_W'($urandom_range(board.l1_limit - 1, 0));
        case ($urandom_range(2))
            0: begin
                lo = board.l1_limit;
                hi = board.l3_limit;
            end
            1: begin
                lo = board.l3_limit;
                hi = board.miss_limit;
            end
            default: begin
                lo = board.miss_limit;
                hi = 1 << lbad_pkg::LAT_W;
            end
        endcase
        if (hi <= lo)
            return lbad_pkg::LAT_W'($urandom);
        return lbad_pkg::LAT_W'($urandom_range(hi - 1, lo));
    endfunction

    task automatic feed_samples(input int count, input bit page0_only, input int l1_share);
        int bias;
        bias = 0;
        for (int n = 0; n < count; n++) begin
            // redraw the hit mix now and then so attack and clean batches alternate
            if (n % 16 == 0)
                bias = (l1_share >= 0) ? l1_share : 25 * $urandom_range(4);
            offer_sample(page0_only ? 1'b0
                                    : lbad_pkg::PAGE_W'($urandom_range(lbad_pkg::PAGES - 1)),
                         pick_latency(bias));
        end
    endtask

    function automatic t_detector_settings random_settings();
        t_detector_settings s;
        s.l1_limit   = lbad_pkg::LAT_W'($urandom_range(300, 10));
        s.l3_limit   = s.l1_limit + lbad_pkg::LAT_W'($urandom_range(400));
        s.miss_limit = s.l3_limit + lbad_pkg::LAT_W'($urandom_range(800));
        if ($urandom_range(4) == 0) begin
            s.l1_limit   = lbad_pkg::LAT_W'($urandom);
            s.l3_limit   = lbad_pkg::LAT_W'($urandom);
            s.miss_limit = lbad_pkg::LAT_W'($urandom);
        end
        s.batch        = ($urandom_range(7) == 0) ? '0
                                                  : lbad_pkg::CNT_W'($urandom_range(12, 1));
        s.attack_pct   = ($urandom_range(7) == 0) ? lbad_pkg::PCT_W'($urandom_range(127, 101))
                                                  : lbad_pkg::PCT_W'($urandom_range(100));
        s.throttle_pct = ($urandom_range(7) == 0) ? lbad_pkg::PCT_W'($urandom_range(127, 101))
                                                  : lbad_pkg::PCT_W'($urandom_range(100));
        s.clear        = lbad_pkg::CLR_W'($urandom_range(15));
        return s;
    endfunction

    initial begin : stimulus
        logic [lbad_pkg::LAT_W-1:0] edge_lat[8];
        t_detector_settings         s;
        edge_lat = '{16'd0, 16'd99, 16'd100, 16'd229, 16'd230, 16'd449, 16'd450, 16'hFFFF};
        cycle_count         = 0;
        samples_sent        = 0;
        settings_applied    = 0;
        held_cycles         = 0;
        hold_request_cycles = 0;
        burst_left          = 0;
        sender_gaps         = 1'b1;
        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= lbad_pkg::CFG_L1_LIMIT;
        i_cfg_wdata  <= '0;
        i_in_valid   <= 1'b0;
        i_page_index <= '0;
        i_latency    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: both sides of every bin edge fill one page-0 batch
        foreach (edge_lat[k])
            offer_sample(1'b0, edge_lat[k]);

        // overlapping limits, zero batch size, zero clear count, percent over 100
        apply_settings('{16'd500, 16'd10, 16'hFFFF, 8'd0, 7'd127, 7'd0, 4'd0});
        offer_sample(1'b1, 16'hFFFF);
        offer_sample(1'b0, 16'd5);
        offer_sample(1'b1, 16'd200);

        // batch size lowered with both pages part way through a batch
        apply_settings('{16'd100, 16'd230, 16'd450, 8'd6, 7'd50, 7'd100, 4'd1});
        offer_sample(1'b0, 16'd20);
        offer_sample(1'b0, 16'd300);
        offer_sample(1'b1, 16'd1000);
        offer_sample(1'b0, 16'd150);
        offer_sample(1'b1, 16'd60);
        apply_settings('{16'd100, 16'd230, 16'd450, 8'd2, 7'd50, 7'd100, 4'd1});
        offer_sample(1'b0, 16'd300);
        offer_sample(1'b1, 16'd40000);

        // largest batch, all L1 hits, share exactly at the attack percent
        sender_gaps = 1'b0;
        apply_settings('{16'd100, 16'd230, 16'd450, 8'd255, 7'd100, 7'd99, 4'd15});
        feed_samples(255, 1'b1, 100);

        // widest and narrowest limits
        sender_gaps = 1'b1;
        apply_settings('{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 7'd0, 7'd127, 4'd1});
        feed_samples(60, 1'b0, -1);
        apply_settings('{16'd0, 16'd0, 16'd0, 8'd3, 7'd100, 7'd0, 4'd3});
        feed_samples(60, 1'b0, -1);

        for (int p = 0; p < 10; p++) begin
            s = random_settings();
            if (p == 3)
                s.clear = 4'd15;
            if (p == 5)
                s.clear = 4'd0;
            sender_gaps = (p % 3 != 0);
            apply_settings(s);
            if (p == 2 || p == 7) begin
                // long receiver hold-off while samples keep coming
                feed_samples(40, 1'b0, -1);
                hold_request_cycles = 150;
                feed_samples(90, 1'b0, -1);
            end else begin
                feed_samples(130, 1'b0, -1);
            end
        end

        wait_idle();
        $display("covered %0d samples and %0d batch reports over %0d register settings",
                 samples_sent, board.reports_seen, settings_applied);
        $display("attack batches %0d, raises %0d, throttles %0d, hold-off %0d cycles",
                 board.attack_batches, board.raises, board.throttle_requests, held_cycles);
        if (board.errors == 0 && board.pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
